[rtl/core/bgod_pkg.sv]
package bgod_pkg;

   localparam int MAX_BANDS = 64;
   localparam int BAND_W    = $clog2(MAX_BANDS);

   localparam int ENERGY_W  = 32;
   localparam int GROWTH_W  = 24;
   localparam int GSUM_W    = 30;
   localparam int ESUM_W    = 38;
   localparam int LTHR_W    = 31;
   localparam int HOLD_W    = 8;
   localparam int DECAY_W   = 8;
   localparam int DEB_W     = 16;
   localparam int FRAC_W    = 8;

   // quotient bits produced by the divider; one more than the growth field
   localparam int QUO_W      = GROWTH_W + 1;
   localparam int DIV_STEPS  = QUO_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int NUM_W      = ENERGY_W + FRAC_W;
   localparam int DVSR_W     = ENERGY_W + 1;
   localparam int MEM_W      = ENERGY_W + HOLD_W;

   localparam logic [GROWTH_W-1:0] GROWTH_MAX = '1;
   localparam logic [GSUM_W-1:0]   GSUM_MAX   = '1;
   localparam logic [ESUM_W-1:0]   ESUM_MAX   = '1;
   localparam logic [QUO_W-1:0]    GROWTH_ONE = QUO_W'(1 << FRAC_W);
   localparam logic [HOLD_W-1:0]   HOLD_MAX   = '1;
   localparam logic [DECAY_W-1:0]  DECAY_MIN  = DECAY_W'(13);
   localparam logic [DECAY_W-1:0]  DECAY_MAX  = DECAY_W'(243);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = ESUM_W;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_BAND       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_BAND      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESHOLD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ENERGY     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_HOLD      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_DECAY     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE       = 3'd7;

   typedef struct packed {
      logic                cmd;
      logic [ENERGY_W-1:0] band_energy;
      logic                last_band;
   } req_type;

   typedef struct packed {
      logic [GROWTH_W-1:0] band_growth;
      logic                frame_done;
      logic [GSUM_W-1:0]   total_growth;
      logic [ESUM_W-1:0]   total_energy;
      logic                attack_start;
      logic                onset_report;
   } rsp_type;

   typedef struct packed {
      logic [BAND_W-1:0]        low_band;
      logic [BAND_W-1:0]        high_band;
      logic signed [LTHR_W-1:0] low_threshold;
      logic [GSUM_W-1:0]        high_threshold;
      logic [ESUM_W-1:0]        min_energy;
      logic [HOLD_W-1:0]        mask_hold_frames;
      logic [DECAY_W-1:0]       mask_decay;
      logic [DEB_W-1:0]         debounce_ticks;
   } cfg_type;

   typedef struct packed {
      logic tick;
      logic capture;
      logic mem_rd;
      logic update;
      logic div_step;
      logic accum;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic need_div;
      logic out_free;
   } dp_sts_type;

endpackage

[rtl/core/band_growth_onset_detector.sv]
// Band growth onset detector.
// req_*: one transaction per band energy (cmd 0) or per debounce tick (cmd 1).
//   Band energies of a frame arrive in band order; last_band closes the frame.
// rsp_*: one transaction per band energy, none for a tick. On the last band
//   frame_done is set and the frame totals and attack/onset flags are valid;
//   otherwise those fields read zero.
// csr_*: register writes, index 0..7, always ready; write only while idle.
// A tick is taken in the idle state. A band passes the read and update
//   states, the steps of the radix-2 divider when its energy exceeds the band
//   mask and the quotient fits in 25 bits, then the accumulate and emit
//   states. Emit loads the result register and waits while the output stalls;
//   the input takes no new transaction until the block is back in idle.
// Reset: registers return to their defaults, all band masks and hold counts
//   read as zero, sums and the attack state clear. No clearing pass is needed.
// Stall: a result waits in the output register while rsp_ready is low; the
//   block then takes ticks and the next band, and holds that band before
//   loading its result; no tick is taken while a band is held.
module band_growth_onset_detector (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bgod_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bgod_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bgod_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bgod_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bgod_pkg::*;

   cfg_type    cfg;
   dp_cmd_type cmd;
   dp_sts_type sts;

   bgod_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bgod_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bgod_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/core/bgod_csr.sv]
module bgod_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bgod_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bgod_pkg::CSR_DATA_W-1:0]    csr_data,
   output bgod_pkg::cfg_type                  cfg
);
   import bgod_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LOW_BAND:       cfg_in.low_band         = csr_data[BAND_W-1:0];
            CSR_HIGH_BAND:      cfg_in.high_band        = csr_data[BAND_W-1:0];
            CSR_LOW_THRESHOLD:  cfg_in.low_threshold    = csr_data[LTHR_W-1:0];
            CSR_HIGH_THRESHOLD: cfg_in.high_threshold   = csr_data[GSUM_W-1:0];
            CSR_MIN_ENERGY:     cfg_in.min_energy       = csr_data[ESUM_W-1:0];
            CSR_MASK_HOLD:      cfg_in.mask_hold_frames = csr_data[HOLD_W-1:0];
            CSR_MASK_DECAY:     cfg_in.mask_decay       = csr_data[DECAY_W-1:0];
            CSR_DEBOUNCE:       cfg_in.debounce_ticks   = csr_data[DEB_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_band         <= '0;
         cfg_ff.high_band        <= BAND_W'(MAX_BANDS - 1);
         cfg_ff.low_threshold    <= LTHR_W'(768);
         cfg_ff.high_threshold   <= GSUM_W'(1792);
         cfg_ff.min_energy       <= ESUM_W'(1);
         cfg_ff.mask_hold_frames <= HOLD_W'(4);
         cfg_ff.mask_decay       <= DECAY_W'(179);
         cfg_ff.debounce_ticks   <= DEB_W'(100);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/bgod_ctrl.sv]
module bgod_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bgod_pkg::dp_sts_type  sts,
   output bgod_pkg::dp_cmd_type  cmd
);
   import bgod_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_ACCUM  = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (sts.is_tick) begin
                  cmd.tick = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            cnt_in     = '0;
            state_in   = sts.need_div ? ST_DIV : ST_ACCUM;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the result register can take the transaction
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[rtl/core/bgod_dp.sv]
module bgod_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  bgod_pkg::cfg_type     cfg,
   input  bgod_pkg::req_type     req_data,
   input  bgod_pkg::dp_cmd_type  cmd,
   output bgod_pkg::dp_sts_type  sts,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bgod_pkg::rsp_type     rsp_data
);
   import bgod_pkg::*;

   // band mask and hold count store; entries not yet written read as zero
   logic [MEM_W-1:0]     mem [MAX_BANDS];
   logic [MAX_BANDS-1:0] vld_ff, vld_in;
   logic [MEM_W-1:0]     rd_ff;
   logic                 rd_vld_ff;

   logic [ENERGY_W-1:0]  energy_ff;
   logic                 last_ff;
   logic [BAND_W-1:0]    idx_ff, idx_in;

   logic                 gt_ff;
   logic                 ovf_ff;
   logic [DVSR_W-1:0]    dvsr_ff;
   logic [DVSR_W-1:0]    rem_ff;
   logic [QUO_W-1:0]     num_ff;
   logic [QUO_W-1:0]     quo_ff;
   logic [GROWTH_W-1:0]  growth_ff;

   logic [GSUM_W-1:0]    gsum_ff, gsum_in;
   logic [ESUM_W-1:0]    esum_ff, esum_in;
   logic [GSUM_W-1:0]    prev_ff, prev_in;
   logic                 hit_ff, hit_in;
   logic [DEB_W-1:0]     deb_ff, deb_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff;

   logic [ENERGY_W-1:0]  mask_cur;
   logic [HOLD_W-1:0]    hold_cur;
   logic                 gt;
   logic [DVSR_W-1:0]    dvsr;
   logic [NUM_W-1:0]     num_full;
   logic                 ovf;
   logic [DECAY_W-1:0]   decay_c;
   logic [NUM_W-1:0]     prod;
   logic [HOLD_W-1:0]    hold_inc;
   logic [ENERGY_W-1:0]  new_mask;
   logic [HOLD_W-1:0]    new_hold;

   logic [DVSR_W:0]      rem_sh;
   logic [DVSR_W:0]      rem_sub;
   logic                 fits;

   logic [QUO_W-1:0]     q_m;
   logic [GROWTH_W-1:0]  growth;

   logic [BAND_W-1:0]    lo, hi;
   logic                 in_range;
   logic [GSUM_W:0]      gsum_add;
   logic [ESUM_W:0]      esum_add;

   logic                 attack;
   logic                 lt_pos;
   logic                 release_hit;
   logic                 decrease_hit;
   rsp_type              rsp_next;

   // mask lookup and update
   assign mask_cur = rd_vld_ff ? rd_ff[MEM_W-1:HOLD_W] : '0;
   assign hold_cur = rd_vld_ff ? rd_ff[HOLD_W-1:0] : '0;
   assign gt       = energy_ff > mask_cur;
   assign dvsr     = {1'b0, mask_cur} + DVSR_W'(1);
   assign num_full = {energy_ff, FRAC_W'(0)};
   // quotient does not fit in QUO_W bits
   assign ovf      = DVSR_W'(num_full[NUM_W-1:QUO_W]) >= dvsr;

   assign decay_c  = (cfg.mask_decay < DECAY_MIN) ? DECAY_MIN :
                     (cfg.mask_decay > DECAY_MAX) ? DECAY_MAX : cfg.mask_decay;
   assign prod     = NUM_W'(mask_cur) * NUM_W'(decay_c);
   assign hold_inc = (hold_cur == HOLD_MAX) ? HOLD_MAX : hold_cur + HOLD_W'(1);
   assign new_mask = gt ? energy_ff :
                     (hold_inc >= cfg.mask_hold_frames) ? prod[NUM_W-1:FRAC_W] : mask_cur;
   assign new_hold = gt ? '0 : hold_inc;

   // restoring divider, one quotient bit per step
   assign rem_sh  = {rem_ff, num_ff[QUO_W-1]};
   assign fits    = rem_sh >= {1'b0, dvsr_ff};
   assign rem_sub = rem_sh - {1'b0, dvsr_ff};

   assign q_m    = quo_ff - GROWTH_ONE;
   assign growth = !gt_ff ? '0 :
                   (ovf_ff || q_m[QUO_W-1]) ? GROWTH_MAX : q_m[GROWTH_W-1:0];

   // swap a reversed band range
   assign lo       = (cfg.high_band < cfg.low_band) ? cfg.high_band : cfg.low_band;
   assign hi       = (cfg.high_band < cfg.low_band) ? cfg.low_band : cfg.high_band;
   assign in_range = (idx_ff >= lo) && (idx_ff <= hi);
   assign gsum_add = {1'b0, gsum_ff} + (GSUM_W + 1)'(growth);
   assign esum_add = {1'b0, esum_ff} + (ESUM_W + 1)'(energy_ff);

   // attack state machine at the end of a frame
   assign attack       = (esum_ff >= cfg.min_energy) && (gsum_ff > cfg.high_threshold) &&
                         !hit_ff && (deb_ff == '0);
   assign lt_pos       = !cfg.low_threshold[LTHR_W-1] && (cfg.low_threshold != '0);
   assign release_hit  = hit_ff && lt_pos && (gsum_ff < cfg.low_threshold[GSUM_W-1:0]);
   assign decrease_hit = hit_ff && cfg.low_threshold[LTHR_W-1] && (gsum_ff < prev_ff);

   always_comb begin
      rsp_next              = '0;
      rsp_next.band_growth  = growth_ff;
      rsp_next.frame_done   = last_ff;
      if (last_ff) begin
         rsp_next.total_growth = gsum_ff;
         rsp_next.total_energy = esum_ff;
         rsp_next.attack_start = attack;
         rsp_next.onset_report = !attack && (release_hit || decrease_hit);
      end
   end

   always_comb begin
      vld_in       = vld_ff;
      idx_in       = idx_ff;
      gsum_in      = gsum_ff;
      esum_in      = esum_ff;
      prev_in      = prev_ff;
      hit_in       = hit_ff;
      deb_in       = deb_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.tick && (deb_ff != '0)) begin
         deb_in = deb_ff - DEB_W'(1);
      end
      if (cmd.update) begin
         vld_in[idx_ff] = 1'b1;
      end
      if (cmd.accum) begin
         if (in_range) begin
            gsum_in = gsum_add[GSUM_W] ? GSUM_MAX : gsum_add[GSUM_W-1:0];
         end
         esum_in = esum_add[ESUM_W] ? ESUM_MAX : esum_add[ESUM_W-1:0];
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (last_ff) begin
            if (attack) begin
               hit_in = 1'b1;
               deb_in = cfg.debounce_ticks;
            end else if (release_hit || decrease_hit) begin
               hit_in = 1'b0;
            end
            prev_in = gsum_ff;
            gsum_in = '0;
            esum_in = '0;
            idx_in  = '0;
         end else begin
            idx_in = (idx_ff == BAND_W'(MAX_BANDS - 1)) ? '0 : idx_ff + BAND_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         idx_ff       <= '0;
         gsum_ff      <= '0;
         esum_ff      <= '0;
         prev_ff      <= '0;
         hit_ff       <= 1'b0;
         deb_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         idx_ff       <= idx_in;
         gsum_ff      <= gsum_in;
         esum_ff      <= esum_in;
         prev_ff      <= prev_in;
         hit_ff       <= hit_in;
         deb_ff       <= deb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         mem[idx_ff] <= {new_mask, new_hold};
      end
      if (cmd.mem_rd) begin
         rd_ff     <= mem[idx_ff];
         rd_vld_ff <= vld_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         energy_ff <= req_data.band_energy;
         last_ff   <= req_data.last_band;
      end
      if (cmd.update) begin
         gt_ff   <= gt;
         ovf_ff  <= ovf;
         dvsr_ff <= dvsr;
         rem_ff  <= DVSR_W'(num_full[NUM_W-1:QUO_W]);
         num_ff  <= num_full[QUO_W-1:0];
         quo_ff  <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= fits ? rem_sub[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
         num_ff <= {num_ff[QUO_W-2:0], 1'b0};
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
      end
      if (cmd.accum) begin
         growth_ff <= growth;
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign sts.is_tick  = req_data.cmd;
   assign sts.need_div = gt && !ovf;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/core/bgod_checker.sv]
module bgod_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  bgod_pkg::req_type  req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  bgod_pkg::rsp_type  rsp_data
);
   import bgod_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // partial frame results carry no totals or flags
   a_partial_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_done |->
         rsp_data.total_growth == '0 && rsp_data.total_energy == '0 &&
         !rsp_data.attack_start && !rsp_data.onset_report)
      else $error("totals on a partial frame");

   // attack and onset never in the same frame
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.attack_start && rsp_data.onset_report))
      else $error("attack and onset together");

   // a band transaction keeps the input closed in the next cycle
   a_band_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.cmd |=> !req_ready)
      else $error("input open while band in flight");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind band_growth_onset_detector bgod_checker u_bgod_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
